// ===== rtl/core/rhtt_pkg.sv =====
// Shared types and constants for the rectangle hit-test table.
package rhtt_pkg;

   localparam int TAG_BITS = 8;
   localparam int REGION_BITS = 4;

   localparam logic CMD_ADD = 1'b0;
   localparam logic CMD_CHECK = 1'b1;

   typedef struct packed {
      logic                add_accepted;
      logic                hit;
      logic [REGION_BITS-1:0] region_number;
      logic [TAG_BITS-1:0] hit_tag;
   } rhtt_result_type;

   typedef struct packed {
      logic                hit;
      logic [TAG_BITS-1:0] tag;
   } rhtt_match_type;

endpackage

// ===== rtl/core/rectangle_hit_test_table_unit.sv =====
// Rectangle hit-test table: add rectangles in order, find the lowest one holding a point.
// Add: the result passes through the pending register into the output register.
// Check: one entry read from the table memory per cycle, the scan ending early on a hit;
//    the scan of the filled entries sets the rate.
// The next item is taken once the result sits in the output register.
// Synchronous reset empties the table (fill count to zero); memory contents are not cleared.
module rectangle_hit_test_table_unit #(
   parameter int REGIONS = 16,
   parameter int COORD_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_command,
   input  logic signed [COORD_BITS-1:0]         req_rect_left,
   input  logic signed [COORD_BITS-1:0]         req_rect_top,
   input  logic signed [COORD_BITS-1:0]         req_rect_right,
   input  logic signed [COORD_BITS-1:0]         req_rect_bottom,
   input  logic [rhtt_pkg::TAG_BITS-1:0]        req_item_tag,
   input  logic signed [COORD_BITS-1:0]         req_point_x,
   input  logic signed [COORD_BITS-1:0]         req_point_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_add_accepted,
   output logic                                 rsp_hit,
   output logic [rhtt_pkg::REGION_BITS-1:0]     rsp_region_number,
   output logic [rhtt_pkg::TAG_BITS-1:0]        rsp_hit_tag
);

   localparam int IDX_W = (REGIONS > 1) ? $clog2(REGIONS) : 1;
   localparam int CNT_W = $clog2(REGIONS + 1);
   localparam int DATA_W = 4 * COORD_BITS + rhtt_pkg::TAG_BITS;
   localparam logic [CNT_W-1:0] FULL = CNT_W'(REGIONS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REPLY
   } state_type;

   state_type                       state_ff, state_in;
   logic [CNT_W-1:0]                fill_ff, fill_in;
   logic [CNT_W-1:0]                rd_idx_ff, rd_idx_in;
   logic                            cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]                cmp_idx_ff, cmp_idx_in;
   logic signed [COORD_BITS-1:0]    px_ff, px_in;
   logic signed [COORD_BITS-1:0]    py_ff, py_in;
   rhtt_pkg::rhtt_result_type       pend_ff, pend_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   rhtt_pkg::rhtt_result_type       rsp_ff, rsp_in;

   logic                            req_accept;
   logic                            out_free;
   logic                            mem_wr_en;
   logic                            mem_rd_en;
   logic [DATA_W-1:0]               mem_wr_data;
   logic [DATA_W-1:0]               mem_rd_data;
   rhtt_pkg::rhtt_match_type        match;
   logic [IDX_W+rhtt_pkg::REGION_BITS-1:0] cmp_idx_ext;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign mem_wr_data = {req_item_tag, req_rect_left, req_rect_top,
                         req_rect_right, req_rect_bottom};
   assign cmp_idx_ext = {{rhtt_pkg::REGION_BITS{1'b0}}, cmp_idx_ff};

   rhtt_table #(
      .DEPTH (REGIONS),
      .ADDR_W(IDX_W),
      .DATA_W(DATA_W)
   ) u_table (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(fill_ff[IDX_W-1:0]),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(rd_idx_ff[IDX_W-1:0]),
      .rd_data(mem_rd_data)
   );

   rhtt_match #(
      .COORD_BITS(COORD_BITS)
   ) u_match (
      .entry  (mem_rd_data),
      .point_x(px_ff),
      .point_y(py_ff),
      .result (match)
   );

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_valid_in = cmp_valid_ff;
      cmp_idx_in   = cmp_idx_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               pend_in = '0;
               if (req_command == rhtt_pkg::CMD_CHECK) begin
                  px_in        = req_point_x;
                  py_in        = req_point_y;
                  rd_idx_in    = '0;
                  cmp_valid_in = 1'b0;
                  state_in     = ST_SCAN;
               end else begin
                  if (fill_ff < FULL) begin
                     mem_wr_en            = 1'b1;
                     fill_in              = fill_ff + 1'b1;
                     pend_in.add_accepted = 1'b1;
                  end
                  state_in = ST_REPLY;
               end
            end
         end
         ST_SCAN: begin
            cmp_valid_in = 1'b0;
            if (cmp_valid_ff && match.hit) begin
               pend_in.hit           = 1'b1;
               pend_in.region_number = cmp_idx_ext[rhtt_pkg::REGION_BITS-1:0];
               pend_in.hit_tag       = match.tag;
               state_in              = ST_REPLY;
            end else if (rd_idx_ff == fill_ff) begin
               pend_in  = '0;
               state_in = ST_REPLY;
            end else begin
               mem_rd_en    = 1'b1;
               rd_idx_in    = rd_idx_ff + 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = rd_idx_ff[IDX_W-1:0];
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rd_idx_ff    <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rd_idx_ff    <= rd_idx_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_idx_ff   <= cmp_idx_in;
         px_ff        <= px_in;
         py_ff        <= py_in;
         pend_ff      <= pend_in;
         rsp_ff       <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_add_accepted  = rsp_ff.add_accepted;
   assign rsp_hit           = rsp_ff.hit;
   assign rsp_region_number = rsp_ff.region_number;
   assign rsp_hit_tag       = rsp_ff.hit_tag;

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL)
      else $error("fill count beyond table size");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (rd_idx_ff <= fill_ff))
      else $error("scan index past filled entries");

   a_add_fills: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_command == rhtt_pkg::CMD_ADD && fill_ff < FULL) |=>
      (fill_ff == $past(fill_ff) + 1'b1))
      else $error("accepted add did not advance fill count");

   a_add_no_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.add_accepted) |-> !rsp_ff.hit)
      else $error("add result carries a hit");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.hit) |->
      (rsp_ff.region_number == '0 && rsp_ff.hit_tag == '0))
      else $error("miss result with nonzero index or tag");
`endif

endmodule

// ===== rtl/core/rhtt_table.sv =====
// Rectangle entry memory: one write port, one read port with registered data.
module rhtt_table #(
   parameter int DEPTH = 16,
   parameter int ADDR_W = 4,
   parameter int DATA_W = 56
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rhtt_match.sv =====
// Inclusive point-in-rectangle test of one table entry.
module rhtt_match #(
   parameter int COORD_BITS = 12
) (
   input  logic [4*COORD_BITS+rhtt_pkg::TAG_BITS-1:0] entry,
   input  logic signed [COORD_BITS-1:0]               point_x,
   input  logic signed [COORD_BITS-1:0]               point_y,
   output rhtt_pkg::rhtt_match_type                   result
);

   // entry layout, msb first: tag, left, top, right, bottom
   logic signed [COORD_BITS-1:0] left;
   logic signed [COORD_BITS-1:0] top;
   logic signed [COORD_BITS-1:0] right;
   logic signed [COORD_BITS-1:0] bottom;

   assign bottom = $signed(entry[COORD_BITS-1:0]);
   assign right  = $signed(entry[2*COORD_BITS-1:COORD_BITS]);
   assign top    = $signed(entry[3*COORD_BITS-1:2*COORD_BITS]);
   assign left   = $signed(entry[4*COORD_BITS-1:3*COORD_BITS]);

   assign result.hit = (point_x >= left) && (point_x <= right) &&
                       (point_y >= top) && (point_y <= bottom);
   assign result.tag = entry[4*COORD_BITS+rhtt_pkg::TAG_BITS-1:4*COORD_BITS];

endmodule

// ===== test/tb_rectangle_hit_test_table_unit.sv =====
// Self-checking testbench for the rectangle hit-test table unit.
module tb_rectangle_hit_test_table_unit;

   localparam int REGIONS = 16;
   localparam int COORD_BITS = 12;
   localparam int HOLD_CYCLES = 300;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_command = rhtt_pkg::CMD_ADD;
   coord_type req_rect_left = '0;
   coord_type req_rect_top = '0;
   coord_type req_rect_right = '0;
   coord_type req_rect_bottom = '0;
   logic [rhtt_pkg::TAG_BITS-1:0] req_item_tag = '0;
   coord_type req_point_x = '0;
   coord_type req_point_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_add_accepted;
   logic rsp_hit;
   logic [rhtt_pkg::REGION_BITS-1:0] rsp_region_number;
   logic [rhtt_pkg::TAG_BITS-1:0] rsp_hit_tag;

   // model of the table contents
   logic slot_enabled[REGIONS];
   coord_type slot_left[REGIONS];
   coord_type slot_top[REGIONS];
   coord_type slot_right[REGIONS];
   coord_type slot_bottom[REGIONS];
   logic [rhtt_pkg::TAG_BITS-1:0] slot_tag[REGIONS];
   int fill_count = 0;

   rhtt_pkg::rhtt_result_type awaited_answers[$];
   int failures = 0;
   logic steady = 1'b0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;

   rectangle_hit_test_table_unit #(
      .REGIONS(REGIONS),
      .COORD_BITS(COORD_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_rect_left(req_rect_left),
      .req_rect_top(req_rect_top),
      .req_rect_right(req_rect_right),
      .req_rect_bottom(req_rect_bottom),
      .req_item_tag(req_item_tag),
      .req_point_x(req_point_x),
      .req_point_y(req_point_y),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_add_accepted(rsp_add_accepted),
      .rsp_hit(rsp_hit),
      .rsp_region_number(rsp_region_number),
      .rsp_hit_tag(rsp_hit_tag)
   );

   always #5 clock = ~clock;

   function automatic rhtt_pkg::rhtt_result_type hit_test_answer(logic cmd,
         coord_type l, coord_type t, coord_type r, coord_type b,
         logic [rhtt_pkg::TAG_BITS-1:0] tag, coord_type x, coord_type y);
      rhtt_pkg::rhtt_result_type res;
      res = '0;
      if (cmd == rhtt_pkg::CMD_ADD) begin
         if (fill_count < REGIONS) begin
            slot_enabled[fill_count] = 1'b1;
            slot_left[fill_count] = l;
            slot_top[fill_count] = t;
            slot_right[fill_count] = r;
            slot_bottom[fill_count] = b;
            slot_tag[fill_count] = tag;
            fill_count++;
            res.add_accepted = 1'b1;
         end
      end else begin
         // scan downward so the lowest matching slot wins
         for (int i = REGIONS - 1; i >= 0; i--) begin
            if (i < fill_count && slot_enabled[i] &&
                  x >= slot_left[i] && x <= slot_right[i] &&
                  y >= slot_top[i] && y <= slot_bottom[i]) begin
               res.hit = 1'b1;
               res.region_number = rhtt_pkg::REGION_BITS'(i);
               res.hit_tag = slot_tag[i];
            end
         end
      end
      return res;
   endfunction

   task automatic send_item(input logic cmd, input coord_type l, input coord_type t,
         input coord_type r, input coord_type b, input logic [rhtt_pkg::TAG_BITS-1:0] tag,
         input coord_type x, input coord_type y);
      rhtt_pkg::rhtt_result_type want;
      while (!steady && $urandom_range(0, 99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_rect_left <= l;
      req_rect_top <= t;
      req_rect_right <= r;
      req_rect_bottom <= b;
      req_item_tag <= tag;
      req_point_x <= x;
      req_point_y <= y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = hit_test_answer(cmd, l, t, r, b, tag, x, y);
      awaited_answers.push_back(want);
   endtask

   task automatic add_rect(input coord_type l, input coord_type t, input coord_type r,
         input coord_type b, input logic [rhtt_pkg::TAG_BITS-1:0] tag);
      send_item(rhtt_pkg::CMD_ADD, l, t, r, b, tag, coord_type'($urandom),
                coord_type'($urandom));
   endtask

   task automatic check_point(input coord_type x, input coord_type y);
      send_item(rhtt_pkg::CMD_CHECK, coord_type'($urandom), coord_type'($urandom),
                coord_type'($urandom), coord_type'($urandom),
                rhtt_pkg::TAG_BITS'($urandom), x, y);
   endtask

   // a coordinate on, just outside or between the two bounds
   function automatic coord_type pick_near(coord_type lo, coord_type hi);
      int lo_i;
      int hi_i;
      lo_i = int'(lo);
      hi_i = int'(hi);
      case ($urandom_range(0, 4))
         0: return coord_type'(lo_i - 1);
         1: return lo;
         2: return hi;
         3: return coord_type'(hi_i + 1);
         default: begin
            if (hi_i >= lo_i)
               return coord_type'(lo_i + int'($urandom_range(0, hi_i - lo_i)));
            return coord_type'($urandom);
         end
      endcase
   endfunction

   task automatic check_random_point();
      int k;
      coord_type x;
      coord_type y;
      if (fill_count > 0 && $urandom_range(0, 4) < 3) begin
         k = int'($urandom_range(0, fill_count - 1));
         x = pick_near(slot_left[k], slot_right[k]);
         y = pick_near(slot_top[k], slot_bottom[k]);
      end else begin
         x = coord_type'($urandom);
         y = coord_type'($urandom);
      end
      check_point(x, y);
   endtask

   task automatic test_empty_table();
      check_point(coord_type'(0), coord_type'(0));
      check_point(coord_type'(-2048), coord_type'(2047));
   endtask

   task automatic test_corner_regions();
      add_rect(coord_type'(-2048), coord_type'(-2048), coord_type'(-2040),
               coord_type'(-2040), 8'hFF);
      add_rect(coord_type'(100), coord_type'(100), coord_type'(50), coord_type'(200),
               8'h55);
      add_rect(coord_type'(2040), coord_type'(2040), coord_type'(2047), coord_type'(2047),
               8'h00);
      add_rect(coord_type'(2000), coord_type'(2000), coord_type'(2047), coord_type'(2047),
               8'hAA);
      check_point(coord_type'(-2048), coord_type'(-2048));
      check_point(coord_type'(-2040), coord_type'(-2040));
      check_point(coord_type'(-2039), coord_type'(-2040));
      check_point(coord_type'(-2040), coord_type'(-2039));
      check_point(coord_type'(2047), coord_type'(2047));
      check_point(coord_type'(2040), coord_type'(2040));
      check_point(coord_type'(2039), coord_type'(2040));
      check_point(coord_type'(2000), coord_type'(2000));
      check_point(coord_type'(1999), coord_type'(2000));
      check_point(coord_type'(75), coord_type'(150));
   endtask

   // random rectangles kept clear of the corners used by the directed slots, mixed with random checks
   task automatic test_random_fill();
      int l;
      int t;
      int w;
      int h;
      while (fill_count < REGIONS - 1) begin
         if ($urandom_range(0, 2) == 0) begin
            l = int'($urandom_range(0, 3400)) - 1900;
            t = int'($urandom_range(0, 3400)) - 1900;
            w = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 400));
            h = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 400));
            if ($urandom_range(0, 5) == 0)
               add_rect(coord_type'(l + w), coord_type'(t), coord_type'(l),
                        coord_type'(t + h), rhtt_pkg::TAG_BITS'($urandom));
            else if ($urandom_range(0, 5) == 0)
               add_rect(coord_type'(l), coord_type'(t + h + 1), coord_type'(l + w),
                        coord_type'(t), rhtt_pkg::TAG_BITS'($urandom));
            else
               add_rect(coord_type'(l), coord_type'(t), coord_type'(l + w),
                        coord_type'(t + h), rhtt_pkg::TAG_BITS'($urandom));
         end else begin
            check_random_point();
         end
      end
   endtask

   task automatic test_table_full();
      add_rect(coord_type'(-2048), coord_type'(2040), coord_type'(-2040),
               coord_type'(2047), 8'h3C);
      add_rect(coord_type'($urandom), coord_type'($urandom), coord_type'($urandom),
               coord_type'($urandom), rhtt_pkg::TAG_BITS'($urandom));
      check_point(coord_type'(-2048), coord_type'(2047));
      check_point(coord_type'(-2044), coord_type'(2039));
   endtask

   task automatic test_random_traffic(input int count);
      for (int i = 0; i < count; i++) begin
         if (i == 300) steady <= 1'b1;
         if (i == 450) steady <= 1'b0;
         if ($urandom_range(0, 9) == 0)
            add_rect(coord_type'($urandom), coord_type'($urandom), coord_type'($urandom),
                     coord_type'($urandom), rhtt_pkg::TAG_BITS'($urandom));
         else
            check_random_point();
      end
   endtask

   task automatic test_backpressure();
      hold_requests <= hold_requests + 1;
      repeat (40) check_random_point();
   endtask

   task automatic check_result();
      rhtt_pkg::rhtt_result_type want;
      if (awaited_answers.size() == 0) begin
         $error("unexpected item on result channel");
         failures++;
      end else begin
         want = awaited_answers.pop_front();
         if (rsp_add_accepted !== want.add_accepted) begin
            $error("add_accepted: expected %0d, got %0d", want.add_accepted, rsp_add_accepted);
            failures++;
         end
         if (rsp_hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, rsp_hit);
            failures++;
         end
         if (rsp_region_number !== want.region_number) begin
            $error("region_number: expected %0d, got %0d", want.region_number,
                   rsp_region_number);
            failures++;
         end
         if (rsp_hit_tag !== want.hit_tag) begin
            $error("hit_tag: expected 0x%02h, got 0x%02h", want.hit_tag, rsp_hit_tag);
            failures++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_result();
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(0, 99) < 6);
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_corner_regions();
      test_random_fill();
      test_table_full();
      test_random_traffic(800);
      test_backpressure();
      req_valid <= 1'b0;
      while (awaited_answers.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (failures == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #5000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
